>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions sampled on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and constants shared by the first-free slot allocator modules.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Built table size and owner id width.
  localparam int SLOTS      = 64;
  localparam int OWNER_BITS = 16;

  // Fixed field widths of the channels.
  localparam int REQ_W   = 2;
  localparam int OWNER_W = 16;
  localparam int IDX_W   = 6;
  localparam int CAP_W   = 7;
  localparam int COUNT_W = 7;

  // Derived internal widths.
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int EC_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [OWNER_W-1:0] owner_id;
    logic [IDX_W-1:0]   slot_index;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   slot_out;
    logic [OWNER_W-1:0] owner_out;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] used_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ffsa_cmd_t;

endpackage

>>> design/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer: takes one item, runs it through the execute state, holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ffsa_pkg::ffsa_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // A new item waits until the previous result has left or leaves now.
  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);

  always_comb begin
    cmd.capture = req_valid && !req_stall;
    cmd.execute = (state == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
          end
          if (cmd.capture) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_capture_then_exec, cmd.capture |=> cmd.execute, "capture not followed by execute")
  `ASSERT_CLK(a_exec_gives_result, cmd.execute |=> rsp_valid, "execute did not present a result")
  `ASSERT_CLK(a_exec_needs_room, cmd.execute |-> !rsp_valid, "result register still full on execute")

endmodule

>>> design/ffsa_dp.sv
// ----------------------------------------------------------------------------
// ffsa_dp
// Datapath: busy map, used count, capacity, owner table and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffsa_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  ffsa_pkg::ffsa_cmd_t            cmd,
  input  ffsa_pkg::req_t                 req,
  output ffsa_pkg::rsp_t                 rsp,
  input  logic                           cfg_we,
  input  logic [ffsa_pkg::CAP_W-1:0]     cfg_data
);

  localparam logic [ffsa_pkg::EC_W-1:0] SLOTS_EC = ffsa_pkg::EC_W'(ffsa_pkg::SLOTS);

  logic [ffsa_pkg::CAP_W-1:0]      capacity;
  logic [ffsa_pkg::SLOTS-1:0]      busy_map;
  logic [ffsa_pkg::SLOTS-1:0]      busy_map_next;
  logic [ffsa_pkg::CNT_W-1:0]      used_total;
  logic [ffsa_pkg::CNT_W-1:0]      used_total_next;
  ffsa_pkg::req_t                  cur;

  logic [ffsa_pkg::EC_W-1:0]       eff_cap;
  logic [ffsa_pkg::EC_W-1:0]       used_ext;
  logic [ffsa_pkg::SLOTS-1:0]      free_mask;
  logic                            found;
  logic [ffsa_pkg::SLOT_W-1:0]     grant;
  logic [ffsa_pkg::SLOT_W-1:0]     cur_addr;
  logic                            idx_in_range;
  logic [ffsa_pkg::OWNER_BITS-1:0] owner_kept;
  logic [ffsa_pkg::OWNER_BITS-1:0] table_rdata;
  logic                            table_we;
  ffsa_pkg::rsp_t                  rsp_next;

  // Owner table: read at capture so the entry is ready in the execute cycle.
  ffsa_ram #(
    .WIDTH (ffsa_pkg::OWNER_BITS),
    .DEPTH (ffsa_pkg::SLOTS)
  ) u_owner_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (grant),
    .wdata (owner_kept),
    .re    (cmd.capture),
    .raddr (ffsa_pkg::SLOT_W'(req.slot_index)),
    .rdata (table_rdata)
  );

  always_comb begin
    eff_cap = (ffsa_pkg::EC_W'(capacity) < SLOTS_EC) ? ffsa_pkg::EC_W'(capacity) : SLOTS_EC;
    used_ext     = ffsa_pkg::EC_W'(used_total);
    cur_addr     = ffsa_pkg::SLOT_W'(cur.slot_index);
    idx_in_range = ffsa_pkg::EC_W'(cur.slot_index) < eff_cap;
    owner_kept   = ffsa_pkg::OWNER_BITS'(cur.owner_id);
    for (int i = 0; i < ffsa_pkg::SLOTS; i++) begin
      free_mask[i] = !busy_map[i] && (ffsa_pkg::EC_W'(i) < eff_cap);
    end
  end

  // Lowest free slot below the capacity.
  always_comb begin
    found = 1'b0;
    grant = '0;
    for (int i = ffsa_pkg::SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        found = 1'b1;
        grant = ffsa_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    busy_map_next   = busy_map;
    used_total_next = used_total;
    table_we        = 1'b0;
    rsp_next        = '0;
    rsp_next.status = 1'b1;
    unique case (ffsa_pkg::req_kind_t'(cur.req_type))
      ffsa_pkg::REQ_ALLOC: begin
        if (owner_kept != '0 && used_ext != eff_cap && found) begin
          table_we               = cmd.execute;
          busy_map_next[grant]   = 1'b1;
          used_total_next        = used_total + ffsa_pkg::CNT_W'(1);
          rsp_next.status        = 1'b0;
          rsp_next.slot_out      = ffsa_pkg::IDX_W'(grant);
        end
      end
      ffsa_pkg::REQ_RELEASE: begin
        if (idx_in_range && busy_map[cur_addr]) begin
          busy_map_next[cur_addr] = 1'b0;
          if (used_total != '0) begin
            used_total_next = used_total - ffsa_pkg::CNT_W'(1);
          end
          rsp_next.status    = 1'b0;
          rsp_next.owner_out = ffsa_pkg::OWNER_W'(table_rdata);
        end
      end
      ffsa_pkg::REQ_QUERY: begin
        if (idx_in_range) begin
          rsp_next.status = 1'b0;
          if (busy_map[cur_addr]) begin
            rsp_next.owner_out = ffsa_pkg::OWNER_W'(table_rdata);
          end
        end
      end
      ffsa_pkg::REQ_CLEAR: begin
        busy_map_next   = '0;
        used_total_next = '0;
        rsp_next.status = 1'b0;
      end
      default: ;
    endcase
    rsp_next.used_count = ffsa_pkg::COUNT_W'(used_total_next);
    if (eff_cap > ffsa_pkg::EC_W'(used_total_next)) begin
      rsp_next.free_count =
        ffsa_pkg::COUNT_W'(eff_cap - ffsa_pkg::EC_W'(used_total_next));
    end else begin
      rsp_next.free_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= ffsa_pkg::CAP_RESET;
      busy_map   <= '0;
      used_total <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.execute) begin
        busy_map   <= busy_map_next;
        used_total <= used_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= req;
    end
    if (cmd.execute) begin
      rsp <= rsp_next;
    end
  end

  // Every busy slot is counted once, including slots above a lowered capacity.
  `ASSERT_CLK(a_count_matches_map, $countones(busy_map) == int'(used_total), "used count off")
  `ASSERT_CLK(a_used_bounded, int'(used_total) <= ffsa_pkg::SLOTS, "used count above slots")
  `ASSERT_CLK(a_grant_is_free, (cmd.execute && table_we) |-> !busy_map[grant], "allocate granted a busy slot")

endmodule

>>> design/first_free_slot_allocator_unit.sv
// An accepted item enters the execute state; its result turns valid as that state ends.
// The owner table read is registered, so each item reads the table as it is captured,
// then decides and writes back in the execute state; no new item is taken meanwhile.
// A stalled result holds off the next item until it is taken.
// Reset (synchronous, rst high): all slots free, used count 0, capacity 64,
// no result pending. Owner table contents are left as they are.
// ----------------------------------------------------------------------------
// first_free_slot_allocator_unit
// First-fit slot allocator with an owner table, free and used counts.
// ----------------------------------------------------------------------------
module first_free_slot_allocator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  ffsa_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output ffsa_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffsa_pkg::CAP_W-1:0] cfg_data
);

  ffsa_pkg::ffsa_cmd_t cmd;

  // Capacity writes are always taken.
  assign cfg_ready = 1'b1;

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  ffsa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .rsp      (rsp),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

endmodule
